// File: hw/rtl/thfd_pkg.sv
// shared types and constants of the topic/header frame deframer
`timescale 1ns / 1ps

package thfd_pkg;

  localparam int unsigned HdrBytes = 10;
  localparam int unsigned HdrCntW  = 4;
  localparam int unsigned LeftW    = 50;
  localparam int unsigned DimW     = 16;
  localparam int unsigned StampW   = 32;
  localparam int unsigned AreaW    = 2 * DimW;
  localparam int unsigned VolW     = 3 * DimW;

  // controller to datapath
  typedef struct packed {
    logic               hdr_store;
    logic [HdrCntW-1:0] hdr_pos;
    logic               mul_area;
    logic               mul_len;
    logic               left_dec;
    logic               out_load;
    logic               out_empty;
    logic               out_first;
    logic               out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic byte_zero;
    logic dim_zero;
    logic left_last;
    logic out_full;
  } sts_t;

endpackage

// File: hw/rtl/thfd_dp.sv
// datapath: header registers, length multiplier, byte counter, result register
`timescale 1ns / 1ps

module thfd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [7:0]                    in_byte_i,
  input  thfd_pkg::cmd_t                cmd_i,
  output thfd_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          empty_frame_o,
  output logic [thfd_pkg::DimW-1:0]     frame_width_o,
  output logic [thfd_pkg::DimW-1:0]     frame_height_o,
  output logic [thfd_pkg::DimW-1:0]     frame_depth_o,
  output logic [thfd_pkg::StampW-1:0]   time_stamp_o,
  output logic                          first_of_frame_o,
  output logic                          last_of_frame_o
);

  logic [thfd_pkg::DimW-1:0]   width_q, height_q, depth_q;
  logic [thfd_pkg::StampW-1:0] stamp_q;
  logic [thfd_pkg::AreaW-1:0]  area_q;
  logic [thfd_pkg::VolW-1:0]   vol_d;
  logic [thfd_pkg::LeftW-1:0]  left_q;
  logic                        out_valid_q;

  // header bytes arrive little endian
  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_store) begin
      case (cmd_i.hdr_pos)
        4'd0:    width_q[7:0]    <= in_byte_i;
        4'd1:    width_q[15:8]   <= in_byte_i;
        4'd2:    height_q[7:0]   <= in_byte_i;
        4'd3:    height_q[15:8]  <= in_byte_i;
        4'd4:    depth_q[7:0]    <= in_byte_i;
        4'd5:    depth_q[15:8]   <= in_byte_i;
        4'd6:    stamp_q[7:0]    <= in_byte_i;
        4'd7:    stamp_q[15:8]   <= in_byte_i;
        4'd8:    stamp_q[23:16]  <= in_byte_i;
        4'd9:    stamp_q[31:24]  <= in_byte_i;
        default: ;
      endcase
    end
  end

  // length in two multiply steps, times four by a shift
  assign vol_d = thfd_pkg::VolW'(area_q) * thfd_pkg::VolW'(depth_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_area) begin
      area_q <= thfd_pkg::AreaW'(width_q) * thfd_pkg::AreaW'(height_q);
    end
    if (cmd_i.mul_len) begin
      left_q <= {vol_d, 2'b00};
    end else if (cmd_i.left_dec) begin
      left_q <= left_q - thfd_pkg::LeftW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_o       <= cmd_i.out_empty ? 8'd0 : in_byte_i;
      empty_frame_o    <= cmd_i.out_empty;
      frame_width_o    <= width_q;
      frame_height_o   <= height_q;
      frame_depth_o    <= depth_q;
      // an empty-frame result is loaded together with the top stamp byte
      time_stamp_o     <= cmd_i.hdr_store ? {in_byte_i, stamp_q[23:0]} : stamp_q;
      first_of_frame_o <= cmd_i.out_first;
      last_of_frame_o  <= cmd_i.out_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.byte_zero = (in_byte_i == 8'd0);
  assign sts_o.dim_zero  = (width_q == '0) || (height_q == '0) || (depth_q == '0);
  assign sts_o.left_last = (left_q[thfd_pkg::LeftW-1:1] == '0);
  assign sts_o.out_full  = out_valid_q && out_stall_i;

endmodule

// File: hw/rtl/thfd_ctrl.sv
// controller: phase sequencing, header byte count and input handshake
`timescale 1ns / 1ps

module thfd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  thfd_pkg::sts_t sts_i,
  output thfd_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_TOPIC,
    S_GATHER,
    S_MUL_AREA,
    S_MUL_LEN,
    S_PAYLOAD
  } state_e;

  state_e                       state_q, state_d;
  logic [thfd_pkg::HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic                         at_start_q, at_start_d;
  logic                         accept;

  assign in_stall_o = (state_q == S_MUL_AREA) || (state_q == S_MUL_LEN) || sts_i.out_full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    hdr_cnt_d  = hdr_cnt_q;
    at_start_d = at_start_q;
    cmd_o      = '0;
    cmd_o.hdr_pos = hdr_cnt_q;
    case (state_q)
      S_TOPIC: begin
        if (accept && sts_i.byte_zero) begin
          state_d   = S_GATHER;
          hdr_cnt_d = '0;
        end
      end
      S_GATHER: begin
        if (accept) begin
          cmd_o.hdr_store = 1'b1;
          hdr_cnt_d       = hdr_cnt_q + thfd_pkg::HdrCntW'(1);
          if (hdr_cnt_q == thfd_pkg::HdrCntW'(thfd_pkg::HdrBytes - 1)) begin
            hdr_cnt_d  = '0;
            at_start_d = 1'b1;
            // last byte is a stamp byte, so the size fields are already final
            if (sts_i.dim_zero) begin
              cmd_o.out_load  = 1'b1;
              cmd_o.out_empty = 1'b1;
              cmd_o.out_first = 1'b1;
              cmd_o.out_last  = 1'b1;
              state_d         = S_TOPIC;
            end else begin
              state_d = S_MUL_AREA;
            end
          end
        end
      end
      S_MUL_AREA: begin
        cmd_o.mul_area = 1'b1;
        state_d        = S_MUL_LEN;
      end
      S_MUL_LEN: begin
        cmd_o.mul_len = 1'b1;
        state_d       = S_PAYLOAD;
      end
      S_PAYLOAD: begin
        if (accept) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_first = at_start_q;
          cmd_o.out_last  = sts_i.left_last;
          at_start_d      = 1'b0;
          if (sts_i.left_last) begin
            state_d    = S_TOPIC;
            at_start_d = 1'b1;
          end else begin
            cmd_o.left_dec = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_TOPIC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_TOPIC;
      hdr_cnt_q  <= '0;
      at_start_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      hdr_cnt_q  <= hdr_cnt_d;
      at_start_q <= at_start_d;
    end
  end

`ifndef ASSERT_OFF
  a_hdr_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_cnt_q < thfd_pkg::HdrCntW'(thfd_pkg::HdrBytes))
    else $error("header count out of range");

  a_mul_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_AREA || state_q == S_MUL_LEN) |-> in_stall_o)
    else $error("request taken during length computation");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_full)
    else $error("result loaded over a stalled result");

  a_len_to_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL_LEN |=> state_q == S_PAYLOAD)
    else $error("length step not followed by payload");
`endif

endmodule

// File: hw/rtl/topic_header_frame_deframer.sv
// top level of the topic/header frame deframer
`timescale 1ns / 1ps

// Byte-stream deframer. Each input request carries one byte. Topic bytes are
// dropped up to and including a zero byte; the next ten bytes form a little
// endian header (width, height, depth as 16 bits, then a 32-bit time stamp).
// The frame then holds width*height*depth*4 payload bytes, each passed out as
// one result request tagged with the header fields and first/last marks. A
// header with a zero size field gives one result with empty_frame set, a zero
// byte and both marks set. Topic bytes and the header bytes of a non-empty
// frame give no result. After the tenth header byte of a non-empty frame the
// input stalls in S_MUL_AREA and S_MUL_LEN while the 50-bit length is formed
// by two registered multiply steps (width*height, then times depth). The
// result sits in an output register, so the input keeps flowing unless that
// register holds a result the sink is stalling.

module topic_header_frame_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_byte_o,
  output logic                        empty_frame_o,
  output logic [thfd_pkg::DimW-1:0]   frame_width_o,
  output logic [thfd_pkg::DimW-1:0]   frame_height_o,
  output logic [thfd_pkg::DimW-1:0]   frame_depth_o,
  output logic [thfd_pkg::StampW-1:0] time_stamp_o,
  output logic                        first_of_frame_o,
  output logic                        last_of_frame_o
);

  thfd_pkg::cmd_t cmd;
  thfd_pkg::sts_t sts;

  // phase control and input handshake
  thfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // header capture, length, byte counter and result register
  thfd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_byte_i        (in_byte_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .empty_frame_o    (empty_frame_o),
    .frame_width_o    (frame_width_o),
    .frame_height_o   (frame_height_o),
    .frame_depth_o    (frame_depth_o),
    .time_stamp_o     (time_stamp_o),
    .first_of_frame_o (first_of_frame_o),
    .last_of_frame_o  (last_of_frame_o)
  );

endmodule
